// ----- src/grubbs_outlier_rejection_unit_macros.svh -----
// Assertion macros shared by the Grubbs outlier rejection RTL.
`ifndef GRUBBS_OUTLIER_REJECTION_UNIT_MACROS_SVH
`define GRUBBS_OUTLIER_REJECTION_UNIT_MACROS_SVH
`ifndef SYNTH
`define GOR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GOR_ASSERT_IMP(label, clk, rst, ante, cons)
`define GOR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/gor_pkg.sv -----
// Types and fixed constants of the Grubbs outlier rejection unit.
package gor_pkg;

  localparam int G0_W     = 11;
  localparam int ERR_W    = 24;
  localparam int CFG_W    = 24;
  localparam int G0_SQ_W  = 2 * G0_W;
  localparam int COUNT_W  = 7;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 56;
  localparam int FRAC_BITS = 8;
  localparam int CRIT_SHIFT = 16;
  localparam int UNIFORM_DIV = 3;

  localparam logic [G0_SQ_W-1:0] G0_SQ_RST = 22'd262144;
  localparam logic [ERR_W-1:0]   ERR_RST   = '0;

  localparam logic [0:0] REG_G0_Q8     = 1'b0;
  localparam logic [0:0] REG_INSTR_ERR = 1'b1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_BEGIN,
    ST_SCAN,
    ST_DEV,
    ST_L1,
    ST_L2,
    ST_S1,
    ST_S2,
    ST_R1,
    ST_R2,
    ST_DD1,
    ST_DD2,
    ST_E2,
    ST_A1,
    ST_A2,
    ST_VDIV,
    ST_MDIV,
    ST_EMIT
  } state_t;

endpackage

// ----- src/gor_in_if.sv -----
// Sample channel: one signed sample and a batch end mark per beat.
interface gor_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source(output valid, sample, last, input ready);
  modport sink(input valid, sample, last, output ready);
endinterface

// ----- src/gor_out_if.sv -----
// Result channel: counts, mean and total variance of one batch per beat.
interface gor_out_if
  import gor_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [COUNT_W-1:0]       kept_count;
  logic [COUNT_W-1:0]       removed_count;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [VAR_W-1:0]         total_variance_q8;

  modport source(output valid, kept_count, removed_count, mean_q8, total_variance_q8,
                 input ready);
  modport sink(input valid, kept_count, removed_count, mean_q8, total_variance_q8,
               output ready);
endinterface

// ----- src/grubbs_outlier_rejection_unit.sv -----
// Grubbs outlier rejection over a batch of samples held in a local memory.
//
// Channel   Dir  Payload                                        Beat
// samples   in   sample, last                                   one sample
// results   out  kept_count, removed_count, mean_q8,            one per batch
//                total_variance_q8
// wr_*      in   wr_index, wr_data                              one register write
//
// Samples load at one beat per cycle into the sample memory while the unit is in its load state.
// After the closing beat each test costs one scan of the batch (one memory read per cycle)
// and six passes of the shift-add multiplier; the closing phase adds up to seven more
// passes and two passes of the restoring divider.
// Reset is synchronous and needs no clearing pass; the memory is read only below the count.
// A finished result waits in the output register while the next batch loads.
`include "grubbs_outlier_rejection_unit_macros.svh"
module grubbs_outlier_rejection_unit
  import gor_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [0:0]       wr_index,
  input  logic [CFG_W-1:0] wr_data,
  gor_in_if.sink           samples,
  gor_out_if.source        results
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AWA  = $clog2(MAX_SAMPLES);
  localparam int SUMW = SB + CW;
  localparam int DEVW = SB + CW + 1;
  localparam int KW   = SB + CW + 2;
  localparam int SQW  = 2 * SB + CW;
  localparam int MW   = 2 * SB + 3 * CW + 56;
  localparam int BW0  = (DEVW > ERR_W) ? DEVW : ERR_W;
  localparam int BW   = (BW0 > 3 * CW) ? BW0 : 3 * CW;
  localparam int DW   = 3 * CW + 2;

  state_t state, state_next;

  logic [G0_SQ_W-1:0] g0_sq;
  logic [ERR_W-1:0]   err;

  logic signed [SB-1:0] mem [MAX_SAMPLES];
  logic signed [SB-1:0] rdata;
  logic                 rd_en;
  logic                 rd_v;
  logic [AWA-1:0]       rd_idx;

  logic [CW-1:0]          cnt;
  logic signed [SUMW-1:0] sum;
  logic [SQW-1:0]         sq;
  logic [CW-1:0]          n;
  logic signed [SUMW-1:0] wsum;
  logic                   final_ph;
  logic                   launched;

  logic [CW-1:0]        scan_idx;
  logic                 best_v;
  logic [DEVW-1:0]      best_key;
  logic [AWA-1:0]       best_idx;
  logic signed [SB-1:0] best_val;
  logic                 have_last;
  logic [DEVW-1:0]      last_key;
  logic [AWA-1:0]       last_idx;

  logic [DEVW-1:0] dev;
  logic [MW-1:0]   lreg;
  logic [MW-1:0]   rreg;
  logic [MW-1:0]   nsp;
  logic [MW-1:0]   ddr;
  logic [MW-1:0]   e2r;
  logic [MW-1:0]   numr;
  logic [DW-1:0]   denr;
  logic [VAR_W-1:0]  var_r;
  logic signed [MEAN_W-1:0] mean_r;

  logic                 out_v;
  logic [COUNT_W-1:0]   out_kept;
  logic [COUNT_W-1:0]   out_removed;
  logic signed [MEAN_W-1:0] out_mean;
  logic [VAR_W-1:0]     out_var;

  logic          mul_start, mul_busy, mul_done;
  logic [MW-1:0] mul_a, mul_p;
  logic [BW-1:0] mul_b;
  logic          div_start, div_done;
  logic [MW-1:0] div_num, div_q;
  logic [DW-1:0] div_den;
  logic          op_done;

  logic                   accept;
  logic                   room;
  logic signed [2*SB-1:0] xsq;
  logic signed [2*SB-1:0] csq;
  logic signed [CW:0]     n0s;
  logic signed [CW:0]     ns;
  logic signed [KW-1:0]   kdiff;
  logic [KW-1:0]          kmag;
  logic [DEVW-1:0]        key;
  logic signed [KW-1:0]   cdiff;
  logic [KW-1:0]          cmag;
  logic [SUMW-1:0]        sum_mag;
  logic                   eligible;
  logic                   better;
  logic                   scan_done;
  logic                   gt;
  logic [CW-1:0]          n_m1;
  logic [DW-1:0]          dd_lo;
  logic                   emit_go;

  assign accept  = samples.valid && samples.ready;
  assign room    = cnt < CW'(MAX_SAMPLES);
  assign xsq     = samples.sample * samples.sample;
  assign csq     = best_val * best_val;
  assign op_done = mul_done || div_done;
  assign n_m1    = n - CW'(1);
  assign dd_lo   = ddr[DW-1:0];
  assign emit_go = !out_v || results.ready;
  assign gt      = lreg > mul_p;

  assign n0s   = {1'b0, cnt};
  assign kdiff = KW'(n0s) * KW'(rdata) - KW'(sum);
  assign kmag  = kdiff[KW-1] ? KW'(-kdiff) : KW'(kdiff);
  assign key   = kmag[DEVW-1:0];

  assign ns    = {1'b0, n};
  assign cdiff = KW'(ns) * KW'(best_val) - KW'(wsum);
  assign cmag  = cdiff[KW-1] ? KW'(-cdiff) : KW'(cdiff);

  assign sum_mag = wsum[SUMW-1] ? SUMW'(-wsum) : SUMW'(wsum);

  assign eligible = !have_last || (key < last_key) || ((key == last_key) && (rd_idx < last_idx));
  assign better   = !best_v || (key >= best_key);
  assign scan_done = (scan_idx == cnt) && !rd_v;

  gor_mul #(.AW(MW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  gor_div #(.NW(MW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g0_sq <= G0_SQ_RST;
      err   <= ERR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_G0_Q8: begin
          g0_sq <= G0_SQ_W'(wr_data[G0_W-1:0]) * G0_SQ_W'(wr_data[G0_W-1:0]);
        end
        REG_INSTR_ERR: begin
          err <= wr_data[ERR_W-1:0];
        end
        default: begin
          err <= err;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[cnt[AWA-1:0]] <= samples.sample;
    end
    if (rd_en) begin
      rdata <= mem[scan_idx[AWA-1:0]];
    end
    rd_idx <= scan_idx[AWA-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && samples.last) begin
          state_next = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        if (cnt > CW'(2)) begin
          state_next = ST_SCAN;
        end else if (cnt == CW'(2)) begin
          state_next = ST_S1;
        end else begin
          state_next = ST_E2;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV: state_next = ST_L1;
      ST_L1: if (op_done) state_next = ST_L2;
      ST_L2: if (op_done) state_next = ST_S1;
      ST_S1: if (op_done) state_next = ST_S2;
      ST_S2: begin
        if (op_done) begin
          state_next = final_ph ? ST_DD1 : ST_R1;
        end
      end
      ST_R1: if (op_done) state_next = ST_R2;
      ST_R2: begin
        if (op_done) begin
          if (gt) begin
            state_next = (n > CW'(3)) ? ST_SCAN : ST_S1;
          end else begin
            state_next = ST_DD1;
          end
        end
      end
      ST_DD1: if (op_done) state_next = ST_DD2;
      ST_DD2: if (op_done) state_next = ST_E2;
      ST_E2: begin
        if (op_done) begin
          state_next = (n >= CW'(2)) ? ST_A1 : ST_VDIV;
        end
      end
      ST_A1: if (op_done) state_next = ST_A2;
      ST_A2: if (op_done) state_next = ST_VDIV;
      ST_VDIV: if (op_done) state_next = ST_MDIV;
      ST_MDIV: if (op_done) state_next = ST_EMIT;
      ST_EMIT: if (emit_go) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    samples.ready = 1'b0;
    rd_en         = 1'b0;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    unique case (state)
      ST_LOAD: samples.ready = 1'b1;
      ST_SCAN: rd_en = scan_idx < cnt;
      ST_L1: begin
        mul_start = !launched;
        mul_a     = MW'(dev);
        mul_b     = BW'(dev);
      end
      ST_L2: begin
        mul_start = !launched;
        mul_a     = lreg;
        mul_b     = BW'(n_m1);
      end
      ST_S1: begin
        mul_start = !launched;
        mul_a     = MW'(sq);
        mul_b     = BW'(n);
      end
      ST_S2: begin
        mul_start = !launched;
        mul_a     = MW'(sum_mag);
        mul_b     = BW'(sum_mag);
      end
      ST_R1: begin
        mul_start = !launched;
        mul_a     = nsp;
        mul_b     = BW'(g0_sq);
      end
      ST_R2: begin
        mul_start = !launched;
        mul_a     = rreg;
        mul_b     = BW'(n);
      end
      ST_DD1: begin
        mul_start = !launched;
        mul_a     = MW'(n);
        mul_b     = BW'(n);
      end
      ST_DD2: begin
        mul_start = !launched;
        mul_a     = ddr;
        mul_b     = BW'(n_m1);
      end
      ST_E2: begin
        mul_start = !launched;
        mul_a     = MW'(err);
        mul_b     = BW'(err);
      end
      ST_A1: begin
        mul_start = !launched;
        mul_a     = e2r;
        mul_b     = ddr[BW-1:0];
      end
      ST_A2: begin
        mul_start = !launched;
        mul_a     = nsp;
        mul_b     = BW'(UNIFORM_DIV);
      end
      ST_VDIV: begin
        div_start = !launched;
        div_num   = numr;
        div_den   = denr;
      end
      ST_MDIV: begin
        div_start = !launched;
        div_num   = MW'(sum_mag) << FRAC_BITS;
        div_den   = DW'(n);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      sum       <= '0;
      sq        <= '0;
      launched  <= 1'b0;
      rd_v      <= 1'b0;
      scan_idx  <= '0;
      best_v    <= 1'b0;
      have_last <= 1'b0;
      final_ph  <= 1'b0;
      n         <= '0;
      out_v     <= 1'b0;
    end else begin
      rd_v <= rd_en;
      if (op_done) begin
        launched <= 1'b0;
      end else if (mul_start || div_start) begin
        launched <= 1'b1;
      end
      if (state == ST_EMIT && emit_go) begin
        out_v <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_v <= 1'b0;
      end
      if (state_next == ST_SCAN && state != ST_SCAN) begin
        scan_idx <= '0;
        best_v   <= 1'b0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (rd_v && eligible && better) begin
        best_v <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          if (accept && room) begin
            cnt <= cnt + CW'(1);
            sum <= sum + SUMW'(samples.sample);
            sq  <= sq + SQW'($unsigned(xsq));
          end
        end
        ST_BEGIN: begin
          n         <= cnt;
          have_last <= 1'b0;
          final_ph  <= !(cnt > CW'(2));
        end
        ST_S2: begin
          if (op_done && final_ph) begin
            final_ph <= 1'b1;
          end
        end
        ST_R2: begin
          if (op_done) begin
            final_ph <= !(gt && (n > CW'(3)));
            if (gt) begin
              n         <= n_m1;
              sq        <= sq - SQW'($unsigned(csq));
              have_last <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            cnt   <= '0;
            sum   <= '0;
            sq    <= '0;
          end
        end
        default: begin
          final_ph <= final_ph;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v && eligible && better) begin
      best_key <= key;
      best_idx <= rd_idx;
      best_val <= rdata;
    end
    case (state)
      ST_BEGIN: wsum <= sum;
      ST_DEV: dev <= cmag[DEVW-1:0];
      ST_L1: if (op_done) lreg <= mul_p << CRIT_SHIFT;
      ST_L2: if (op_done) lreg <= mul_p;
      ST_S1: if (op_done) rreg <= mul_p;
      ST_S2: if (op_done) nsp <= rreg - mul_p;
      ST_R1: if (op_done) rreg <= mul_p;
      ST_R2: begin
        if (op_done && gt) begin
          wsum     <= wsum - SUMW'(best_val);
          last_key <= best_key;
          last_idx <= best_idx;
        end
      end
      ST_DD1: if (op_done) ddr <= mul_p;
      ST_DD2: if (op_done) ddr <= mul_p;
      ST_E2: begin
        if (op_done) begin
          e2r  <= mul_p;
          numr <= mul_p << FRAC_BITS;
          denr <= DW'(UNIFORM_DIV);
        end
      end
      ST_A1: if (op_done) rreg <= mul_p;
      ST_A2: begin
        if (op_done) begin
          numr <= (rreg + mul_p) << FRAC_BITS;
          denr <= dd_lo + (dd_lo << 1);
        end
      end
      ST_VDIV: begin
        if (op_done) begin
          var_r <= (div_q[MW-1:VAR_W] != '0) ? '1 : div_q[VAR_W-1:0];
        end
      end
      ST_MDIV: begin
        if (op_done) begin
          if (!wsum[SUMW-1]) begin
            mean_r <= (div_q[MW-1:MEAN_W-1] != '0) ? {1'b0, {(MEAN_W-1){1'b1}}}
                                                   : $signed(div_q[MEAN_W-1:0]);
          end else if ((div_q[MW-1:MEAN_W] != '0) ||
                       (div_q[MEAN_W-1] && (div_q[MEAN_W-2:0] != '0))) begin
            mean_r <= {1'b1, {(MEAN_W-1){1'b0}}};
          end else begin
            mean_r <= $signed(-div_q[MEAN_W-1:0]);
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_kept    <= COUNT_W'(n);
          out_removed <= COUNT_W'(cnt - n);
          out_mean    <= mean_r;
          out_var     <= var_r;
        end
      end
      default: begin
        dev <= dev;
      end
    endcase
  end

  assign results.valid             = out_v;
  assign results.kept_count        = out_kept;
  assign results.removed_count     = out_removed;
  assign results.mean_q8           = out_mean;
  assign results.total_variance_q8 = out_var;

  `GOR_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_SAMPLES))
  `GOR_ASSERT_IMP(a_test_needs_three, clk, rst, state == ST_R2, n > CW'(2))
  `GOR_ASSERT_IMP(a_mul_idle_start, clk, rst, mul_start, !mul_busy)
  `GOR_ASSERT_NEXT(a_emit_clears, clk, rst, state == ST_EMIT && emit_go, cnt == '0 && out_v)

endmodule

// ----- src/gor_mul.sv -----
// Shift-and-add multiplier taking one multiplier bit per cycle.
module gor_mul #(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          busy,
  output logic          done,
  output logic [AW-1:0] p
);

  logic [AW-1:0] acc;
  logic [AW-1:0] a_sh;
  logic [BW-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (b_sh[BW-1:1] == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign p = acc;

endmodule

// ----- src/gor_div.sv -----
// Restoring divider producing one quotient bit per cycle.
module gor_div #(
  parameter int NW = 64,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] q
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [NW-1:0]   qsh;
  logic [DW-1:0]   d;
  logic [DW:0]     shifted;
  logic [DW+1:0]   trial;

  assign shifted = {rem, qsh[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qsh <= num;
      d   <= den;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW-1:0];
        qsh <= {qsh[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        qsh <= {qsh[NW-2:0], 1'b0};
      end
    end
  end

  assign q = qsh;

endmodule

// ----- tb/tb_grubbs_outlier_rejection_unit.sv -----
// Self-checking testbench for the Grubbs outlier rejection unit, with its own batch predictor.
module tb_grubbs_outlier_rejection_unit;
  import gor_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N = 64;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam logic [55:0] VAR_SAT = {56{1'b1}};

  typedef logic [191:0] wide_t;
  typedef struct packed {
    logic [COUNT_W-1:0] kept;
    logic [COUNT_W-1:0] removed;
    logic [MEAN_W-1:0]  mean;
    logic [VAR_W-1:0]   variance;
  } batch_summary_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [0:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  gor_in_if #(.SAMPLE_BITS(24)) smp_if ();
  gor_out_if res_if ();

  grubbs_outlier_rejection_unit u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .samples(smp_if.sink), .results(res_if.source)
  );

  always #6 clk = ~clk;

  longint batch_store[MAX_N];
  int unsigned batch_len;
  longint batch_sum;
  logic [10:0] g0_setting;
  logic [23:0] err_setting;
  batch_summary_t summary_q[$];

  int unsigned errors, items_sent, batches_checked, total_removed, idle_cycles;
  int unsigned stall_left;
  bit gaps_on, stalls_on;

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic batch_summary_t summarise_batch();
    batch_summary_t r;
    logic [63:0] dkey[MAX_N];
    int rank[MAX_N];
    int unsigned n0, n, j;
    longint sum, c, m;
    wide_t sq, spread, lhs, rhs, dd, acc, q, e2, dev, ms;
    n0 = batch_len;
    sum = batch_sum;
    sq = '0;
    for (int i = 0; i < n0; i++) begin
      dkey[i] = magnitude(longint'(n0) * batch_store[i] - sum);
      sq += wide_t'(magnitude(batch_store[i])) * wide_t'(magnitude(batch_store[i]));
      j = i;
      while (j > 0 && dkey[rank[j-1]] > dkey[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    n = n0;
    while (n > 2) begin
      c = batch_store[rank[n-1]];
      dev = wide_t'(magnitude(longint'(n) * c - sum));
      ms = wide_t'(magnitude(sum));
      spread = wide_t'(n) * sq - ms * ms;
      lhs = dev * dev * wide_t'(65536) * wide_t'(n - 1);
      rhs = spread * wide_t'(g0_setting) * wide_t'(g0_setting) * wide_t'(n);
      if (!(lhs > rhs)) break;
      sum -= c;
      sq -= wide_t'(magnitude(c)) * wide_t'(magnitude(c));
      n--;
    end
    e2 = wide_t'(err_setting) * wide_t'(err_setting);
    if (n >= 2) begin
      ms = wide_t'(magnitude(sum));
      spread = wide_t'(n) * sq - ms * ms;
      dd = wide_t'(n) * wide_t'(n) * wide_t'(n - 1);
      acc = wide_t'(3) * spread + e2 * dd;
      q = (acc * wide_t'(256)) / (wide_t'(3) * dd);
    end else begin
      q = (e2 * wide_t'(256)) / wide_t'(3);
    end
    if (q > wide_t'(VAR_SAT)) q = wide_t'(VAR_SAT);
    m = (sum * 256) / longint'(n);
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    r.kept = n[6:0];
    r.removed = 7'(n0 - n);
    r.mean = m[31:0];
    r.variance = q[55:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(longint x, bit is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample <= x[23:0];
    smp_if.last <= is_last;
    do @(posedge clk); while (!smp_if.ready);
    items_sent++;
    if (batch_len < MAX_N) begin
      batch_store[batch_len] = x;
      batch_len++;
      batch_sum += x;
    end
    if (is_last) begin
      summary_q.insert(summary_q.size(), summarise_batch());
      batch_len = 0;
      batch_sum = 0;
    end
  endtask

  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_G0_Q8) g0_setting = value[10:0];
    else err_setting = value;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch in batch %0d: %s got %0h expected %0h", batches_checked, what, got, want);
  endtask

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic send_random_batch(int unsigned len);
    longint centre, spread;
    centre = $urandom_range(0, 3) == 0 ? longint'($signed($urandom_range(0, 16777215)) - 8388608)
                                       : longint'($urandom_range(0, 2000)) - 1000;
    spread = longint'(1) << $urandom_range(0, 16);
    for (int unsigned i = 0; i < len; i++) begin
      longint x;
      case ($urandom_range(0, 19))
        0: x = longint'($urandom_range(0, 16777215)) - 8388608;
        1, 2: x = centre + ($urandom_range(0, 1) ? 1 : -1) * spread * $urandom_range(5, 60);
        default: x = centre + longint'($urandom_range(0, 2 * spread)) - spread;
      endcase
      send_sample(clamp24(x), i == len - 1);
    end
  endtask

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 14);
    return $urandom_range(15, 40);
  endfunction

  task automatic test_directed();
    send_sample(-8388608, 1'b1);
    send_sample(8388607, 1'b0);
    send_sample(-8388608, 1'b1);
    repeat (4) send_sample(100, 1'b0);
    send_sample(100, 1'b1);
    send_sample(0, 1'b0);
    send_sample(10, 1'b0);
    send_sample(-10, 1'b0);
    send_sample(0, 1'b1);
    send_sample(10, 1'b0);
    send_sample(11, 1'b0);
    send_sample(9, 1'b0);
    send_sample(10, 1'b0);
    send_sample(8388607, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(-8388608, 1'b0);
    send_sample(8388607, 1'b0);
    send_sample(0, 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < 70; i++)
      send_sample(longint'($urandom_range(0, 200)) - 100 + (i == 3 ? 5000000 : 0), i == 69);
    wait_drained();
  endtask

  task automatic test_register_sweep();
    logic [10:0] g0_vals[5];
    logic [23:0] err_vals[5];
    g0_vals = '{11'd0, 11'd2047, 11'd256, 11'($urandom_range(300, 900)), 11'd512};
    err_vals = '{24'hffffff, 24'd0, 24'd1, 24'($urandom), 24'($urandom_range(0, 5000))};
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_G0_Q8, 24'(g0_vals[k]));
      write_reg(REG_INSTR_ERR, err_vals[k]);
      repeat (6) send_random_batch(pick_len());
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    write_reg(REG_G0_Q8, 24'($urandom_range(200, 700)));
    write_reg(REG_INSTR_ERR, 24'($urandom_range(0, 100000)));
    while (items_sent < 850) begin
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat (5) send_random_batch(pick_len());
      if (items_sent > 500 && items_sent < 560) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (summary_q.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(res_if.kept_count), 64'd0);
        end else begin
          batch_summary_t want;
          want = summary_q.pop_front();
          if (res_if.kept_count !== want.kept)
            report_mismatch("kept_count", 64'(res_if.kept_count), 64'(want.kept));
          if (res_if.removed_count !== want.removed)
            report_mismatch("removed_count", 64'(res_if.removed_count), 64'(want.removed));
          if (res_if.mean_q8 !== want.mean)
            report_mismatch("mean_q8", 64'($unsigned(res_if.mean_q8)), 64'(want.mean));
          if (res_if.total_variance_q8 !== want.variance)
            report_mismatch("total_variance_q8", 64'(res_if.total_variance_q8),
                            64'(want.variance));
          batches_checked++;
          total_removed += want.removed;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (stalls_on && ($urandom_range(0, 99) < 3)) begin
        stall_left <= $urandom_range(10, 40);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !stalls_on || ($urandom_range(0, 99) < 65);
      end
    end
  end

  always @(posedge clk) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", summary_q.size());
      $display("** grubbs_outlier_rejection_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_G0_Q8;
    wr_data <= '0;
    smp_if.valid <= 1'b0;
    smp_if.sample <= '0;
    smp_if.last <= 1'b0;
    g0_setting = 11'd512;
    err_setting = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_register_sweep();
    test_random_traffic();
    $display("Sent %0d samples in %0d batches; %0d samples were rejected as outliers.",
             items_sent, batches_checked, total_removed);
    $display("Covered register extremes, full store, ties, zero spread and small batches.");
    if (errors == 0 && summary_q.size() == 0) begin
      $display("** grubbs_outlier_rejection_unit: PASSED **");
    end else begin
      $display("** grubbs_outlier_rejection_unit: FAILED **");
    end
    $finish;
  end

endmodule
